// File: hdl/u8vd_pkg.sv
// Shared types, constants and helper functions of the UTF-8 validating decoder.
package u8vd_pkg;

    localparam int CODE_W  = 21;
    localparam int PART_W  = 31;
    localparam int LEN_W   = 3;
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 24;
    localparam int OUT_TUSER_W = 2;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-1:0] REG_UTF16_OUTPUT = 3'd0;

    // Number of results that one step hands to the output queue.
    localparam logic [1:0] CNT_NONE = 2'd0;
    localparam logic [1:0] CNT_ONE  = 2'd1;
    localparam logic [1:0] CNT_TWO  = 2'd2;

    typedef struct packed {
        logic [CODE_W-1:0] code_unit;
        logic              bad_sequence;
        logic              run_last;
        logic              string_done;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } step_t;

    function automatic logic [LEN_W-1:0] shortest_length(input logic [PART_W-1:0] cp);
        logic [LEN_W-1:0] len;
        if (cp < 31'h80)              len = 3'd1;
        else if (cp < 31'h800)        len = 3'd2;
        else if (cp < 31'h10000)      len = 3'd3;
        else if (cp < 31'h200000)     len = 3'd4;
        else if (cp < 31'h4000000)    len = 3'd5;
        else                          len = 3'd6;
        return len;
    endfunction

    // Rejects values beyond Unicode, surrogates, the FDD0..FDEF block and xxFFFE/xxFFFF.
    function automatic logic code_allowed(input logic [PART_W-1:0] cp);
        logic ok;
        ok = (cp < 31'h110000) &&
             (cp[PART_W-1:11] != 20'h0001B) &&
             ((cp < 31'hFDD0) || (cp > 31'hFDEF)) &&
             (cp[15:1] != 15'h7FFF);
        return ok;
    endfunction

endpackage

// File: hdl/u8vd_cfg.sv
// APB register block holding the output format select.
module u8vd_cfg
    import u8vd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic                  utf16_output
);

    logic utf16_output_reg;
    logic utf16_output_next;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready && (paddr == REG_UTF16_OUTPUT);

    always_comb
    begin
        utf16_output_next = utf16_output_reg;
        if (wr_en)
        begin
            utf16_output_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            utf16_output_reg <= 1'b0;
        end
        else
        begin
            utf16_output_reg <= utf16_output_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr == REG_UTF16_OUTPUT)
        begin
            prdata = {{(APB_DATA_W-1){1'b0}}, utf16_output_reg};
        end
    end

    assign utf16_output = utf16_output_reg;

endmodule

// File: hdl/u8vd_core.sv
// Input register, sequence state and the combinational decode and check of each byte.
module u8vd_core
    import u8vd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_TDATA_W-1:0] s_tdata,
    input  logic                  s_tlast,
    input  logic                  room,
    input  logic                  utf16_output,
    output step_t                 step
);

    logic                  in_valid_reg;
    logic                  in_valid_next;
    logic [7:0]            data_reg;
    logic                  end_reg;
    logic                  accept;
    logic                  consume;

    logic [PART_W-1:0]     partial_reg;
    logic [PART_W-1:0]     partial_next;
    logic [LEN_W-1:0]      remain_reg;
    logic [LEN_W-1:0]      remain_next;
    logic [LEN_W-1:0]      seqlen_reg;
    logic [LEN_W-1:0]      seqlen_next;
    logic                  error_reg;
    logic                  error_next;

    logic                  lead_ok;
    logic [LEN_W-1:0]      lead_len;
    logic [6:0]            lead_bits;
    logic [PART_W-1:0]     acc;
    logic [PART_W-1:0]     emit_cp;
    logic [LEN_W-1:0]      emit_len;
    logic                  emit_ok;
    logic [19:0]           offset;
    logic [CODE_W-1:0]     high_unit;
    logic [CODE_W-1:0]     low_unit;
    logic                  do_error;
    logic                  do_emit;

    assign s_tready = !in_valid_reg || room;
    assign accept   = s_tvalid && s_tready;
    assign consume  = in_valid_reg && room;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (consume)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg <= s_tdata;
            end_reg  <= s_tlast;
        end
    end

    // Lead byte classification.
    always_comb
    begin
        lead_ok   = 1'b1;
        lead_len  = 3'd1;
        lead_bits = data_reg[6:0];
        priority if (data_reg[7] == 1'b0)
        begin
            lead_len  = 3'd1;
            lead_bits = data_reg[6:0];
        end
        else if (data_reg[7:5] == 3'b110)
        begin
            lead_len  = 3'd2;
            lead_bits = {2'b0, data_reg[4:0]};
        end
        else if (data_reg[7:4] == 4'b1110)
        begin
            lead_len  = 3'd3;
            lead_bits = {3'b0, data_reg[3:0]};
        end
        else if (data_reg[7:3] == 5'b11110)
        begin
            lead_len  = 3'd4;
            lead_bits = {4'b0, data_reg[2:0]};
        end
        else if (data_reg[7:2] == 6'b111110)
        begin
            lead_len  = 3'd5;
            lead_bits = {5'b0, data_reg[1:0]};
        end
        else if (data_reg[7:1] == 7'b1111110)
        begin
            lead_len  = 3'd6;
            lead_bits = {6'b0, data_reg[0]};
        end
        else
        begin
            lead_ok = 1'b0;
        end
    end

    assign acc      = {partial_reg[PART_W-7:0], data_reg[5:0]};
    assign emit_cp  = (remain_reg == 3'd0) ? {{(PART_W-7){1'b0}}, lead_bits} : acc;
    assign emit_len = (remain_reg == 3'd0) ? 3'd1 : seqlen_reg;
    assign emit_ok  = code_allowed(emit_cp) && (shortest_length(emit_cp) == emit_len);

    assign offset    = 20'(emit_cp[CODE_W-1:0] - 21'h10000);
    assign high_unit = 21'h0D800 + {11'b0, offset[19:10]};
    assign low_unit  = 21'h0DC00 + {11'b0, offset[9:0]};

    always_comb
    begin
        partial_next = partial_reg;
        remain_next  = remain_reg;
        seqlen_next  = seqlen_reg;
        error_next   = error_reg;
        do_error     = 1'b0;
        do_emit      = 1'b0;
        step         = '0;

        if (consume)
        begin
            if (error_reg)
            begin
                // The rest of a bad string is dropped until its end byte.
                if (end_reg)
                begin
                    error_next   = 1'b0;
                    partial_next = '0;
                    remain_next  = '0;
                    seqlen_next  = '0;
                end
            end
            else if (remain_reg == 3'd0)
            begin
                if (!lead_ok)
                begin
                    do_error = 1'b1;
                end
                else if (lead_len == 3'd1)
                begin
                    do_emit = 1'b1;
                end
                else if (end_reg)
                begin
                    do_error = 1'b1;
                end
                else
                begin
                    partial_next = {{(PART_W-7){1'b0}}, lead_bits};
                    remain_next  = lead_len - 3'd1;
                    seqlen_next  = lead_len;
                end
            end
            else
            begin
                if (data_reg[7:6] != 2'b10)
                begin
                    do_error = 1'b1;
                end
                else if (remain_reg == 3'd1)
                begin
                    do_emit = 1'b1;
                end
                else if (end_reg)
                begin
                    do_error = 1'b1;
                end
                else
                begin
                    partial_next = acc;
                    remain_next  = remain_reg - 3'd1;
                end
            end

            if (do_emit && !emit_ok)
            begin
                do_error = 1'b1;
            end

            if (do_error)
            begin
                partial_next       = '0;
                remain_next        = '0;
                seqlen_next        = '0;
                error_next         = !end_reg;
                step.count         = CNT_ONE;
                step.first         = '{code_unit: '0, bad_sequence: 1'b1,
                                       run_last: 1'b1, string_done: end_reg};
            end
            else if (do_emit)
            begin
                partial_next = '0;
                remain_next  = '0;
                seqlen_next  = '0;
                if (utf16_output && (emit_cp >= 31'h10000))
                begin
                    step.count  = CNT_TWO;
                    step.first  = '{code_unit: high_unit, bad_sequence: 1'b0,
                                    run_last: 1'b0, string_done: end_reg};
                    step.second = '{code_unit: low_unit, bad_sequence: 1'b0,
                                    run_last: 1'b1, string_done: end_reg};
                end
                else
                begin
                    step.count = CNT_ONE;
                    step.first = '{code_unit: emit_cp[CODE_W-1:0], bad_sequence: 1'b0,
                                   run_last: 1'b1, string_done: end_reg};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            partial_reg  <= '0;
            remain_reg   <= '0;
            seqlen_reg   <= '0;
            error_reg    <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            partial_reg  <= partial_next;
            remain_reg   <= remain_next;
            seqlen_reg   <= seqlen_next;
            error_reg    <= error_next;
        end
    end

endmodule

// File: hdl/u8vd_outq.sv
// Four-entry result queue that takes up to two results a cycle and drives the output stream.
module u8vd_outq
    import u8vd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  step_t                  step,
    output logic                   room,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic [OUT_TUSER_W-1:0] m_tuser,
    output logic                   m_tlast
);

    result_t              q_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_next;
    logic [Q_CNT_W-1:0]   count_reg;
    logic [Q_CNT_W-1:0]   count_next;
    logic                 pop;
    logic [Q_PTR_W-1:0]   wr_ptr_plus;
    result_t              head;

    // Room is judged on the registered fill alone, so no path runs from m_tready to s_tready.
    assign room     = count_reg <= Q_CNT_W'(Q_DEPTH - 2);
    assign m_tvalid = count_reg != '0;
    assign pop      = m_tvalid && m_tready;
    assign head     = q_reg[rd_ptr_reg];

    assign m_tdata  = {{(OUT_TDATA_W-CODE_W){1'b0}}, head.code_unit};
    assign m_tuser  = {head.string_done, head.bad_sequence};
    assign m_tlast  = head.run_last;

    assign wr_ptr_plus = wr_ptr_reg + Q_PTR_W'(1);
    assign wr_ptr_next = wr_ptr_reg + Q_PTR_W'(step.count);
    assign rd_ptr_next = rd_ptr_reg + Q_PTR_W'(pop);
    assign count_next  = count_reg + Q_CNT_W'(step.count) - Q_CNT_W'(pop);

    always_ff @(posedge clk)
    begin
        if (step.count != CNT_NONE)
        begin
            q_reg[wr_ptr_reg] <= step.first;
        end
        if (step.count == CNT_TWO)
        begin
            q_reg[wr_ptr_plus] <= step.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: hdl/utf8_validating_decoder_top.sv
// Top level of the UTF-8 validating decoder: byte stream in, code units out.
//
//  channel  | dir | handshake          | contents
//  ---------+-----+--------------------+---------------------------------------------
//  s_*      | in  | s_tvalid/s_tready  | s_tdata: data_byte; s_tlast: string_end
//  m_*      | out | m_tvalid/m_tready  | m_tdata: code_unit; m_tuser: bad_sequence,
//           |     |                    | string_done; m_tlast: run_last
//  APB      | in  | psel/penable       | register 0 at address 0: utf16_output
//
// One byte is taken per cycle unless the input stalls; it is decoded while it sits in the input
// register and its results enter a four-entry output queue, from which m_* is driven.
// A surrogate pair gives two output items, fewer than the four input bytes of its sequence,
// so one byte per cycle holds whenever the output side keeps up.
// A byte waits in the input register while the queue holds more than two results, and the
// input stalls only once that register is occupied as well.
// Reset clears the sequence state, the queue and the format select at once; no clearing pass.
module utf8_validating_decoder_top
    import u8vd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [7:0] data_byte
    input  logic                   s_tlast,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [20:0] code_unit, [23:21] zero
    output logic [OUT_TUSER_W-1:0] m_tuser,   // [0] bad_sequence, [1] string_done
    output logic                   m_tlast,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);

    logic  utf16_output;
    logic  room;
    step_t step;

    u8vd_cfg u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .utf16_output (utf16_output)
    );

    u8vd_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .room         (room),
        .utf16_output (utf16_output),
        .step         (step)
    );

    u8vd_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .room     (room),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// File: hdl/utf8_validating_decoder_chk.sv
// Port-level checker for the UTF-8 validating decoder, bound to the top level.
module utf8_validating_decoder_chk
    import u8vd_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata,
    input logic [OUT_TUSER_W-1:0] m_tuser,
    input logic                   m_tlast
);

    // An error item carries a zero code and closes its run.
    a_error_form: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> (m_tdata == '0) && m_tlast)
        else $error("error item with nonzero code or open run");

    // Only a high surrogate opens a two-item run.
    a_pair_head: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> !m_tuser[0] && (m_tdata[23:10] == 14'h0036))
        else $error("run opened by something other than a high surrogate");

    // The low surrogate is ready in the very next cycle after the high one is taken.
    a_pair_tail: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=>
            m_tvalid && m_tlast && (m_tdata[23:10] == 14'h0037) &&
            (m_tuser[1] == $past(m_tuser[1])))
        else $error("high surrogate not followed by its low surrogate");

    // No code unit lies beyond the Unicode range.
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata <= 24'h10FFFF))
        else $error("code unit out of range");

    // A stalled output item holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
            $stable(m_tlast))
        else $error("stalled output item changed");

endmodule

bind utf8_validating_decoder_top utf8_validating_decoder_chk u_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// File: verif/tb.sv
// Self-checking testbench for the UTF-8 validating decoder: byte strings in, code units checked.
module tb;
    import u8vd_pkg::*;

    // Follows the decoder state byte by byte and keeps the code units it must produce.
    class decoded_units;
        logic        mode16;
        logic [30:0] partial;
        logic [2:0]  remaining;
        logic [2:0]  seq_len;
        logic        err_latched;
        result_t     awaited[$];
        int          bytes_seen;
        int          live_bytes;
        int          strings;
        int          n_results;
        int          n_errors;
        int          n_pairs;
        int          n_fail;

        function new();
            mode16 = 1'b0;
            err_latched = 1'b0;
            clear_seq();
        endfunction

        function void clear_seq();
            partial = '0;
            remaining = '0;
            seq_len = '0;
        endfunction

        function void push_unit(logic [20:0] code, logic bad, logic last, logic fin);
            result_t r;
            r.code_unit = code;
            r.bad_sequence = bad;
            r.run_last = last;
            r.string_done = fin;
            awaited.push_back(r);
        endfunction

        function void flag_error(logic fin);
            push_unit('0, 1'b1, 1'b1, fin);
            clear_seq();
            err_latched = !fin;
        endfunction

        function bit point_legal(logic [30:0] cp);
            return cp < 31'h110000 &&
                   (cp & 31'h7FFFF800) != 31'hD800 &&
                   (cp < 31'hFDD0 || cp > 31'hFDEF) &&
                   (cp & 31'hFFFE) != 31'hFFFE;
        endfunction

        function int min_len(logic [30:0] cp);
            if (cp < 31'h80) return 1;
            if (cp < 31'h800) return 2;
            if (cp < 31'h10000) return 3;
            if (cp < 31'h200000) return 4;
            if (cp < 31'h4000000) return 5;
            return 6;
        endfunction

        function void finish_point(logic [30:0] cp, logic fin);
            logic [30:0] v;
            if (!point_legal(cp) || min_len(cp) != seq_len) begin
                flag_error(fin);
                return;
            end
            clear_seq();
            if (mode16 && cp >= 31'h10000) begin
                v = cp - 31'h10000;
                push_unit(21'((v >> 10) + 31'hD800), 1'b0, 1'b0, fin);
                push_unit(21'((v & 31'h3FF) + 31'hDC00), 1'b0, 1'b1, fin);
            end
            else
                push_unit(cp[20:0], 1'b0, 1'b1, fin);
        endfunction

        function void take_byte(logic [7:0] c, logic fin);
            int          lead_len;
            logic [30:0] lead_bits;
            bytes_seen++;
            if (fin)
                strings++;
            // Once a string has failed, its remaining bytes are swallowed.
            if (err_latched) begin
                if (fin) begin
                    err_latched = 1'b0;
                    clear_seq();
                end
                return;
            end
            live_bytes++;
            if (remaining == 0) begin
                lead_bits = '0;
                casez (c)
                    8'b0???????: begin lead_len = 1; lead_bits = 31'(c); end
                    8'b110?????: begin lead_len = 2; lead_bits = 31'(c & 8'h1F); end
                    8'b1110????: begin lead_len = 3; lead_bits = 31'(c & 8'h0F); end
                    8'b11110???: begin lead_len = 4; lead_bits = 31'(c & 8'h07); end
                    8'b111110??: begin lead_len = 5; lead_bits = 31'(c & 8'h03); end
                    8'b1111110?: begin lead_len = 6; lead_bits = 31'(c & 8'h01); end
                    default:     lead_len = 0;
                endcase
                if (lead_len == 0) begin
                    flag_error(fin);
                    return;
                end
                seq_len = 3'(lead_len);
                if (lead_len == 1)
                    finish_point(lead_bits, fin);
                else if (fin)
                    flag_error(fin);
                else begin
                    partial = lead_bits;
                    remaining = 3'(lead_len - 1);
                end
                return;
            end
            if (c[7:6] != 2'b10) begin
                flag_error(fin);
                return;
            end
            partial = {partial[24:0], c[5:0]};
            remaining = remaining - 3'd1;
            if (remaining == 0)
                finish_point(partial, fin);
            else if (fin)
                flag_error(fin);
        endfunction

        function void match_unit(result_t got);
            result_t want;
            if (awaited.size() == 0) begin
                $error("code unit %h (bad_sequence %b) arrived with none outstanding",
                       got.code_unit, got.bad_sequence);
                n_fail++;
                return;
            end
            want = awaited.pop_front();
            n_results++;
            if (want.bad_sequence)
                n_errors++;
            if (!want.run_last)
                n_pairs++;
            if (got.code_unit !== want.code_unit) begin
                $error("code_unit: expected %h, got %h", want.code_unit, got.code_unit);
                n_fail++;
            end
            if (got.bad_sequence !== want.bad_sequence) begin
                $error("bad_sequence: expected %b, got %b", want.bad_sequence, got.bad_sequence);
                n_fail++;
            end
            if (got.run_last !== want.run_last) begin
                $error("run_last: expected %b, got %b", want.run_last, got.run_last);
                n_fail++;
            end
            if (got.string_done !== want.string_done) begin
                $error("string_done: expected %b, got %b", want.string_done, got.string_done);
                n_fail++;
            end
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;   // [7:0] data_byte
    logic                   s_tlast = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;        // [20:0] code_unit, [23:21] zero
    logic [OUT_TUSER_W-1:0] m_tuser;        // [0] bad_sequence, [1] string_done
    logic                   m_tlast;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr = '0;
    logic [APB_DATA_W-1:0]  pwdata = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    decoded_units dec;
    result_t      seen;
    logic [7:0]   str_buf[$];
    int           src_idle_pct = 0;
    int           snk_idle_pct = 0;

    localparam logic [30:0] BOUNDARY_POINTS [0:9] = '{
        31'h10FFFF, 31'h110000, 31'hD7FF, 31'hE000, 31'hFDCF,
        31'hFDF0, 31'hFFFD, 31'h1FFFF, 31'h7FFFFFFF, 31'h10000
    };

    utf8_validating_decoder_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial begin
        #3000000;
        $display("simulation failed");
        $finish;
    end

    // Both handshakes are sampled at the edge, before any input driven there takes effect.
    always @(posedge clk) begin
        if (rst_n) begin
            if (s_tvalid && s_tready)
                dec.take_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready) begin
                seen.code_unit = m_tdata[CODE_W-1:0];
                seen.bad_sequence = m_tuser[0];
                seen.run_last = m_tlast;
                seen.string_done = m_tuser[1];
                dec.match_unit(seen);
            end
        end
    end

    initial begin
        wait (rst_n);
        forever begin
            @(posedge clk);
            if (snk_idle_pct != 0 && $urandom_range(0, 99) < snk_idle_pct) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    task send_byte(input logic [7:0] b, input logic fin);
        if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= fin;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    // First byte of the string sits in the highest of the n bytes of w.
    task send_seq(input int n, input logic [63:0] w);
        int i;
        for (i = 0; i < n; i++)
            send_byte(w[8*(n-1-i) +: 8], i == n - 1);
    endtask

    task settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (dec.awaited.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task set_mode(input logic utf16);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= REG_UTF16_OUTPUT;
        pwdata <= {{(APB_DATA_W-1){1'b0}}, utf16};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        dec.mode16 = utf16;
    endtask

    function automatic void push_encoded(logic [30:0] cp, int len);
        logic [7:0] lead;
        int         k;
        if (len == 1)
            str_buf.push_back({1'b0, cp[6:0]});
        else begin
            lead = 8'((8'hFF << (8 - len)) | (cp >> (6 * (len - 1))));
            str_buf.push_back(lead);
            for (k = len - 2; k >= 0; k--)
                str_buf.push_back(8'(8'h80 | ((cp >> (6 * k)) & 31'h3F)));
        end
    endfunction

    function automatic logic [30:0] pick_point(int kind);
        case (kind)
            0: return 31'($urandom_range(0, 'h7F));
            1: return 31'($urandom_range('h80, 'h7FF));
            2: return 31'($urandom_range('h800, 'hFFFF));
            3: return 31'($urandom_range('h10000, 'h10FFFF));
            default:
                case ($urandom_range(0, 6))
                    0: return 31'(31'hD800 + $urandom_range(0, 'h7FF));
                    1: return 31'(31'hFDD0 + $urandom_range(0, 'h1F));
                    2: return 31'(($urandom_range(0, 16) << 16) | 31'hFFFE |
                                  $urandom_range(0, 1));
                    3: return 31'($urandom_range('h110000, 'h1FFFFF));
                    4: return 31'($urandom_range('h200000, 'h3FFFFFF));
                    5: return 31'($urandom_range('h4000000, 'h7FFFFFFF));
                    default: return BOUNDARY_POINTS[$urandom_range(0, 9)];
                endcase
        endcase
    endfunction

    // Mostly well-formed characters; now and then a rejected code point, an overlong
    // form, a stray byte or a sequence with its tail cut off.
    task send_random_string();
        int          chunks;
        int          r;
        int          len;
        int          i;
        logic [30:0] cp;
        str_buf.delete();
        chunks = $urandom_range(1, 6);
        for (i = 0; i < chunks; i++) begin
            r = $urandom_range(0, 99);
            if (r < 88) begin
                r = $urandom_range(0, 99);
                cp = pick_point(r < 35 ? 0 : r < 55 ? 1 : r < 80 ? 2 : 3);
                push_encoded(cp, dec.min_len(cp));
            end
            else if (r < 94) begin
                cp = pick_point(4);
                push_encoded(cp, dec.min_len(cp));
            end
            else if (r < 96) begin
                cp = pick_point($urandom_range(0, 3));
                len = dec.min_len(cp);
                push_encoded(cp, $urandom_range(len + 1, 6));
            end
            else if (r < 98)
                str_buf.push_back(8'($urandom_range(0, 255)));
            else begin
                cp = pick_point($urandom_range(1, 3));
                len = dec.min_len(cp);
                push_encoded(cp, len);
                repeat ($urandom_range(1, len - 1)) void'(str_buf.pop_back());
            end
        end
        for (i = 0; i < str_buf.size(); i++)
            send_byte(str_buf[i], i == str_buf.size() - 1);
    endtask

    initial begin
        int ph;
        int target;
        dec = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        src_idle_pct = 20;
        snk_idle_pct = 20;
        set_mode(1'b0);
        // NUL and the largest one- and two-byte code points, then a four-byte sequence cut off at the end.
        send_seq(7, {8'h00, 8'h7F, 8'hDF, 8'hBF, 8'hF4, 8'h8F, 8'hBF});
        send_seq(1, {8'hBD});
        send_seq(1, {8'hFF});
        send_seq(2, {8'hC0, 8'h80});
        send_seq(3, {8'hED, 8'hA0, 8'h80});
        send_seq(3, {8'hEF, 8'hBF, 8'hBE});
        send_seq(2, {8'hFE, 8'h41});
        send_seq(3, {8'hE0, 8'hC2, 8'h41});
        send_seq(1, {8'hC3});
        // The format select changes halfway through a four-byte sequence.
        send_byte(8'hF0, 1'b0);
        send_byte(8'h90, 1'b0);
        settle();
        set_mode(1'b1);
        send_byte(8'h80, 1'b0);
        send_byte(8'h80, 1'b1);

        for (ph = 0; ph < 8; ph++) begin
            settle();
            set_mode(ph == 0 ? 1'b0 : ph == 1 ? 1'b1 : 1'($urandom_range(0, 1)));
            if (ph == 3 || ph == 7) begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            else begin
                src_idle_pct = $urandom_range(5, 35);
                snk_idle_pct = $urandom_range(5, 35);
            end
            target = dec.live_bytes + 72;
            while (dec.live_bytes < target)
                send_random_string();
        end
        settle();

        $display("Covered %0d bytes in %0d strings (%0d skipped after errors), both formats.",
                 dec.bytes_seen, dec.strings, dec.bytes_seen - dec.live_bytes);
        $display("Checked %0d code units: %0d error results, %0d surrogate pairs.",
                 dec.n_results, dec.n_errors, dec.n_pairs);
        if (dec.n_fail == 0 && dec.awaited.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// File: files.f
hdl/u8vd_pkg.sv
hdl/u8vd_cfg.sv
hdl/u8vd_core.sv
hdl/u8vd_outq.sv
hdl/utf8_validating_decoder_top.sv
hdl/utf8_validating_decoder_chk.sv
verif/tb.sv
